/* src/itoa_pkg.sv */
// Shared constants, character codes and helper functions for the integer to ASCII converter.
// Used by the converter top level, its double-dabble step unit and its port checker.
package itoa_pkg;

    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int S_TDATA_W          = 64;
    localparam int M_TDATA_W          = 8;
    localparam int CHAR_W             = 7;
    localparam int DABBLE_BITS        = 4;

    // Radix mode carried in tuser.
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A_LC  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_F_LC  = 7'h66;

    localparam logic [CHAR_W-1:0] DIGIT_SET [0:15] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return DIGIT_SET[d];
    endfunction

    // A BCD digit of five or more would overflow when doubled, so it is moved up by three.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        return (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

endpackage

/* src/integer_to_ascii_radix.sv */
// Integer to ASCII text converter, signed decimal (tuser 0) or lower-case hex (tuser 1).
// Decimal: after the input transfer, the value runs through the double-dabble step unit,
// then leading zero digits are skipped (the final digit always stays), then the characters go out.
// Hex: no double-dabble conversion; the nibbles go straight to zero skipping. A negative
// decimal number gets a minus sign first; s_axis_tready is high only when idle.
// aresetn is synchronous, active low, and clears the sequencer and the output valid.
module integer_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [63:0] value
    input  logic [0:0]           s_axis_tuser,  // [0] op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [6:0] char_code, [7] zero
    output logic                 m_axis_tlast   // last
);

    localparam int STEPS      = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
    localparam int BIN_W      = STEPS * DABBLE_BITS;
    localparam int HEX_DIGITS = STEPS;
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int BCD_W      = NDIG * 4;
    localparam int HEX_SHIFT  = BCD_W - BIN_W;
    localparam int REM_W      = $clog2(NDIG + 1);
    localparam int STEP_W     = $clog2(STEPS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              neg_reg, neg_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] raw;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [BIN_W-1:0]      mag_pad;
    logic [3:0]            top_digit;
    logic                  slot_free;
    logic [BCD_W-1:0]      dab_bcd;
    logic [BIN_W-1:0]      dab_bin;
    logic [BCD_W-1:0]      bcd_shifted;

    itoa_dabble #(
        .BCD_W(BCD_W),
        .BIN_W(BIN_W)
    ) u_dabble (
        .bcd_in (bcd_reg),
        .bin_in (bin_reg),
        .bcd_out(dab_bcd),
        .bin_out(dab_bin)
    );

    assign raw         = s_axis_tdata[VALUE_BITS-1:0];
    assign neg_in      = (s_axis_tuser[0] == OP_DEC) && raw[VALUE_BITS-1];
    assign mag_in      = neg_in ? (~raw + VALUE_BITS'(1)) : raw;
    assign mag_pad     = BIN_W'(mag_in);
    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign bcd_shifted = {bcd_reg[BCD_W-5:0], 4'h0};
    // The output register can take a character when it is empty or being drained.
    assign slot_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        bin_next       = bin_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    neg_next = neg_in;
                    if (s_axis_tuser[0] == OP_HEX) begin
                        // Hex digits are the nibbles themselves, aligned to the top.
                        bcd_next   = BCD_W'(mag_pad) << HEX_SHIFT;
                        rem_next   = REM_W'(HEX_DIGITS);
                        state_next = ST_SKIP;
                    end else begin
                        bcd_next   = '0;
                        bin_next   = mag_pad;
                        step_next  = STEP_W'(STEPS);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                bcd_next  = dab_bcd;
                bin_next  = dab_bin;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    rem_next   = REM_W'(NDIG);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Leading zeros are dropped, but the final digit always stays.
                if (top_digit == 4'h0 && rem_reg > REM_W'(1)) begin
                    bcd_next = bcd_shifted;
                    rem_next = rem_reg - REM_W'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(top_digit);
                    out_last_next  = (rem_reg == REM_W'(1));
                    bcd_next       = bcd_shifted;
                    rem_next       = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
        bin_reg      <= bin_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* src/itoa_dabble.sv */
// Combinational double-dabble step: moves DABBLE_BITS binary bits into a BCD accumulator.
// Depends on itoa_pkg for the step width and the BCD digit correction.
module itoa_dabble
    import itoa_pkg::*;
#(
    parameter int BCD_W = 80,
    parameter int BIN_W = 64
) (
    input  logic [BCD_W-1:0] bcd_in,
    input  logic [BIN_W-1:0] bin_in,
    output logic [BCD_W-1:0] bcd_out,
    output logic [BIN_W-1:0] bin_out
);

    localparam int NDIG = BCD_W / 4;

    always_comb begin
        logic [BCD_W-1:0] b;
        logic [BIN_W-1:0] r;
        b = bcd_in;
        r = bin_in;
        for (int k = 0; k < DABBLE_BITS; k++) begin
            for (int j = 0; j < NDIG; j++) begin
                b[j*4 +: 4] = bcd_adjust(b[j*4 +: 4]);
            end
            {b, r} = {b[BCD_W-2:0], r, 1'b0};
        end
        bcd_out = b;
        bin_out = r;
    end

endmodule

/* src/itoa_checker.sv */
// Port-level checker for the integer to ASCII converter, bound to its top level.
// Depends on itoa_pkg for the character codes.
module itoa_checker
    import itoa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // The converter works on one number at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a conversion is in progress");

    // A stalled result transfer holds its character and flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // Only a minus sign, a decimal digit or a lower-case hex letter is sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (m_axis_tdata[7] == 1'b0) &&
            ((m_axis_tdata[6:0] == CHAR_MINUS) ||
             (m_axis_tdata[6:0] >= CHAR_ZERO && m_axis_tdata[6:0] <= CHAR_NINE) ||
             (m_axis_tdata[6:0] >= CHAR_A_LC && m_axis_tdata[6:0] <= CHAR_F_LC)))
        else $error("illegal character code");

    // A sign is always followed by at least one digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[6:0] == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign marked as last character");

    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for integer_to_ascii_radix: decimal and hex text of 64-bit values.
// Depends on itoa_pkg for port widths, character codes and the digit table.
`timescale 1ns / 100ps

module tb
    import itoa_pkg::*;
();

    // Predicts the character stream of every accepted number and checks each result transfer.
    class text_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] code;
            logic              last;
        } char_t;

        char_t expected_chars[$];
        int    mismatches = 0;

        function void note_input(logic [S_TDATA_W-1:0] value, logic op);
            logic [63:0]       mag;
            logic [63:0]       radix;
            logic [3:0]        digit;
            logic [CHAR_W-1:0] text[$];
            char_t             c;
            bit                neg;
            neg   = (op == OP_DEC) && value[63];
            // The most negative value maps onto its exact unsigned magnitude here.
            mag   = neg ? (~value + 64'd1) : value;
            radix = (op == OP_HEX) ? 64'd16 : 64'd10;
            do begin
                digit = 4'(mag % radix);
                text.push_front(DIGIT_SET[digit]);
                mag = mag / radix;
            end while (mag != 64'd0);
            if (neg)
                text.push_front(CHAR_MINUS);
            foreach (text[i]) begin
                c.code = text[i];
                c.last = (i == text.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [M_TDATA_W-1:0] data, logic last);
            char_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected result: char_code %h, last %b", data[CHAR_W-1:0], last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (data[CHAR_W-1:0] !== want.code) begin
                $error("char_code: expected %h, got %h", want.code, data[CHAR_W-1:0]);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                mismatches++;
            end
            if (data[M_TDATA_W-1:CHAR_W] !== '0) begin
                $error("tdata padding: expected %h, got %h", 1'b0, data[M_TDATA_W-1:CHAR_W]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    logic quiet      = 1'b0;
    int   stall_left = 0;

    text_scoreboard sb = new();

    integer_to_ascii_radix i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls come in random bursts until the quiet tail of the run, when tready stays high.
    always @(posedge aclk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tlast);
    end

    // Valid stays high after a transfer so that back-to-back items need no extra edge.
    task automatic send_item(logic [S_TDATA_W-1:0] value, logic op);
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= value;
        s_axis_tuser[0] <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(value, op);
    endtask

    task automatic idle_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return full;
            1:       return 64'($urandom_range(0, 999));
            2:       return full >> $urandom_range(0, 63);
            3:       return -(full >> $urandom_range(0, 63));
            default: return 64'h8000_0000_0000_0000 >> $urandom_range(0, 1);
        endcase
    endfunction

    logic [63:0] corner_values[$] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd16, -64'd1, -64'd10,
        64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
        64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd1000000000000000000
    };

    initial begin
        int n_random;
        n_random = 96;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_values[i]) begin
            send_item(corner_values[i], OP_DEC);
            send_item(corner_values[i], OP_HEX);
        end

        for (int k = 0; k < n_random; k++) begin
            if (k == n_random / 2)
                drain_results();
            if (k == n_random - 20)
                quiet <= 1'b1;
            if (k < n_random - 20 && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 3));
            send_item(random_value(), $urandom_range(0, 1) ? OP_HEX : OP_DEC);
        end

        drain_results();
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
src/itoa_pkg.sv
src/itoa_dabble.sv
src/integer_to_ascii_radix.sv
src/itoa_checker.sv
verif/tb.sv
